// ===== rtl/core/sacf_pkg.sv =====
package sacf_pkg;

    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 8;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int OFF_W  = 5;
    localparam int IDXW_W = 4;
    localparam int WAYC_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE     = 2'd2;

    localparam logic [OFF_W-1:0]  RST_LINE_SIZE_LOG2  = 5'd4;
    localparam logic [IDXW_W-1:0] RST_SET_INDEX_WIDTH = 4'd8;
    localparam logic [WAYC_W-1:0] RST_WAYS_IN_USE     = 4'd8;

endpackage

// ===== rtl/core/sacf_ram.sv =====
module sacf_ram #(
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/set_assoc_cache_fifo_lookup.sv =====
// Tag lookup of a set-associative cache with FIFO replacement.
//
// Lookup requests enter on the s_axis beat channel: tdata holds the 32-bit
// byte address. Each request produces exactly one m_axis beat whose tdata
// bit 0 is the hit flag (1 = valid matching line found, 0 = miss; a miss
// fills the way named by the set's FIFO pointer and advances the pointer).
// The user must write line size, set index width and the number of ways in
// use on the configuration port while no lookup is in flight; unenforced.
//
// A single tag comparator is stepped over the ways of the set, one tag RAM
// read per cycle. A lookup reads the set state, compares the ways in turn
// up to the first hit or the last of the w ways in use, fills on a miss and
// loads the result. A new request is taken only once that result is loaded.
//
// After reset the block sweeps the set state RAM once, clearing the valid
// bits and FIFO pointers of all MAX_SETS sets, one set per cycle; s_axis is
// not ready during the sweep. The result sits in an output register; if the
// receiver stalls, the sequencer waits for it and then takes the next
// request. MAX_SETS and MAX_WAYS must be powers of two.
module set_assoc_cache_fifo_lookup #(
    parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] address
    input  logic [sacf_pkg::ADDR_W-1:0]     i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] hit, [7:1] zero
    output logic [7:0]                      o_m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [sacf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int CMP_W  = (WCNT_W > sacf_pkg::WAYC_W) ? WCNT_W : sacf_pkg::WAYC_W;
    localparam int META_W = MAX_WAYS + WAY_W;
    localparam int TAG_AW = SET_W + WAY_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_META  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;

    logic [sacf_pkg::OFF_W-1:0]  r_cfg_off;
    logic [sacf_pkg::IDXW_W-1:0] r_cfg_iw;
    logic [sacf_pkg::WAYC_W-1:0] r_cfg_ways;

    logic [SET_W-1:0]           r_clr_idx;
    logic [SET_W-1:0]           r_set;
    logic [sacf_pkg::TAG_W-1:0] r_tag;
    logic [MAX_WAYS-1:0]        r_valid_vec;
    logic [WAY_W-1:0]           r_ptr;
    logic [WAY_W-1:0]           r_way;
    logic                       r_hit;
    logic                       r_out_valid;
    logic                       r_out_hit;

    // Address decode of the incoming request.
    logic [sacf_pkg::ADDR_W-1:0] in_shifted;
    logic [sacf_pkg::ADDR_W-1:0] in_mask;
    logic [sacf_pkg::ADDR_W-1:0] in_set_full;
    logic [5:0]                  in_total;
    logic [SET_W-1:0]            in_set;
    logic [sacf_pkg::TAG_W-1:0]  in_tag;

    always_comb begin
        in_shifted  = i_s_axis_tdata >> r_cfg_off;
        in_mask     = ~({sacf_pkg::ADDR_W{1'b1}} << r_cfg_iw);
        in_set_full = in_shifted & in_mask;
        in_set      = (MAX_SETS > 1) ? in_set_full[SET_W-1:0] : '0;
        in_total    = {1'b0, r_cfg_off} + {2'b00, r_cfg_iw};
        if (in_total >= 6'd32) begin
            in_tag = '0;
        end else begin
            in_tag = i_s_axis_tdata >> in_total[4:0];
        end
    end

    // Effective way count: zero acts as one, saturates at MAX_WAYS.
    logic [CMP_W-1:0] ways_eff;

    always_comb begin
        ways_eff = CMP_W'(r_cfg_ways);
        if (ways_eff == '0) begin
            ways_eff = CMP_W'(1);
        end else if (ways_eff > CMP_W'(MAX_WAYS)) begin
            ways_eff = CMP_W'(MAX_WAYS);
        end
    end

    logic                       s_accept;
    logic                       out_free;
    logic [META_W-1:0]          meta_rdata;
    logic [sacf_pkg::TAG_W-1:0] tag_rdata;
    logic                       meta_we;
    logic [SET_W-1:0]           meta_waddr;
    logic [META_W-1:0]          meta_wdata;
    logic [SET_W-1:0]           meta_raddr;
    logic                       tag_we;
    logic [TAG_AW-1:0]          tag_waddr;
    logic [TAG_AW-1:0]          tag_raddr;
    logic [WAY_W-1:0]           fill_way;
    logic [CMP_W-1:0]           fill_next;
    logic [WAY_W-1:0]           fill_ptr_next;
    logic [MAX_WAYS-1:0]        fill_valid;
    logic                       way_hit;
    logic                       last_way;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // The shared comparator looks at one way per cycle.
    assign way_hit  = r_valid_vec[r_way] && (tag_rdata == r_tag);
    assign last_way = (CMP_W'(r_way) == (ways_eff - CMP_W'(1)));

    // A stale pointer (ways in use lowered) restarts the fill at way 0.
    always_comb begin
        fill_way = r_ptr;
        if (CMP_W'(r_ptr) >= ways_eff) begin
            fill_way = '0;
        end
        fill_next = CMP_W'(fill_way) + CMP_W'(1);
        if (fill_next >= ways_eff) begin
            fill_ptr_next = '0;
        end else begin
            fill_ptr_next = fill_next[WAY_W-1:0];
        end
        fill_valid = r_valid_vec | (MAX_WAYS'(1) << fill_way);
    end

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_set;
        meta_wdata = {fill_ptr_next, fill_valid};
        tag_we     = 1'b0;
        tag_waddr  = {r_set, fill_way};
        meta_raddr = in_set;
        tag_raddr  = {r_set, r_way + WAY_W'(1)};
        if (r_state == S_META) begin
            tag_raddr = {r_set, {WAY_W{1'b0}}};
        end
        case (r_state)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr_idx;
                meta_wdata = '0;
            end
            S_FILL: begin
                meta_we = 1'b1;
                tag_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    sacf_ram #(
        .WIDTH (META_W),
        .AW    (SET_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    sacf_ram #(
        .WIDTH (sacf_pkg::TAG_W),
        .AW    (TAG_AW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_tag),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // Sequencer: clearing sweep, set state read, way-by-way compare, fill, result.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == {SET_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (way_hit) begin
                    n_state = S_DONE;
                end else if (last_way) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_way       <= '0;
            r_cfg_off   <= sacf_pkg::RST_LINE_SIZE_LOG2;
            r_cfg_iw    <= sacf_pkg::RST_SET_INDEX_WIDTH;
            r_cfg_ways  <= sacf_pkg::RST_WAYS_IN_USE;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sacf_pkg::CFG_LINE_SIZE_LOG2: begin
                        r_cfg_off <= i_cfg_data;
                    end
                    sacf_pkg::CFG_SET_INDEX_WIDTH: begin
                        r_cfg_iw <= i_cfg_data[sacf_pkg::IDXW_W-1:0];
                    end
                    sacf_pkg::CFG_WAYS_IN_USE: begin
                        r_cfg_ways <= i_cfg_data[sacf_pkg::WAYC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_META) begin
                r_way <= '0;
            end else if (r_state == S_CMP) begin
                r_way <= r_way + WAY_W'(1);
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
        if (r_state == S_META) begin
            r_valid_vec <= meta_rdata[MAX_WAYS-1:0];
            r_ptr       <= meta_rdata[META_W-1:MAX_WAYS];
        end
        if (r_state == S_CMP) begin
            r_hit <= way_hit;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_hit <= r_hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_hit};

endmodule
